// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/psched_pkg.sv
// ----------------------------------------------------------------------------
// psched_pkg
// shared types and constants of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package psched_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = SLOT_W + 1;

   localparam logic [19:0] MAX20 = 20'hFFFFF;
   localparam logic [23:0] MAX24 = 24'hFFFFFF;

   // item kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_SCAN_END,
      ST_FETCH,
      ST_UPDATE,
      ST_SETTLE,
      ST_REPLY
   } state_type;

   // static part of a slot, written by a load
   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  priority_level;
      logic [15:0] burst_time;
      logic [15:0] arrival_time;
   } task_entry_type;

   // dynamic part of a slot, written when the slot is served
   typedef struct packed {
      logic [19:0] start_time;
      logic [15:0] remaining;
   } prog_entry_type;

   // current winner of the selection scan
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       arrival_time;
      logic [15:0]       burst_time;
      logic [7:0]        priority_level;
      logic [7:0]        task_id;
   } pick_best_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [7:0]  task_id;
      logic [7:0]  priority_level;
      logic [15:0] burst_time;
      logic [15:0] arrival_time;
      logic [3:0]  slot;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [19:0] idle_ticks;
      logic [23:0] sum_waiting;
      logic [23:0] sum_turnaround;
      logic        all_done;
      logic [19:0] response;
      logic [19:0] waiting;
      logic [19:0] turnaround;
      logic [19:0] finish_time;
      logic        finished;
      logic [7:0]  run_id;
      logic [3:0]  run_slot;
      logic        busy_res;
   } rsp_word_type;

endpackage

// File: rtl/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// priority scheduler over a task table held in two synchronous rams
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | load slot, time tick or restart run
//  rsp_     | out       | one result word per request word
//  csr_     | in/out    | task_count register at byte address 0
//
// load, restart, other words and ticks once all are done go through apply and reply.
// other ticks scan the counted slots, one task ram entry per cycle, then go through
// scan end, fetch, update, settle and reply; with no ready slot, fetch goes to reply.
// synchronous reset clears control, counters and flags; the rams are not cleared.
// a new word is accepted while the previous result waits in the output register;
// the reply step holds until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler_unit import psched_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: slot, arrival_time, burst_time, priority_level, task_id
   input  logic [55:0]  req_tdata,
   // tuser: kind
   input  logic [1:0]   req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: busy_res, run_slot, run_id, finished, finish_time, turnaround,
   //        waiting, response, all_done, sum_turnaround, sum_waiting, idle_ticks
   output logic [167:0] rsp_tdata,
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   state_type state_ff, state_in;

   req_word_type req_word;
   logic [1:0]   kind_ff;
   req_word_type item_ff;

   logic [4:0]          task_count_ff;
   logic [CNT_W-1:0]    eff_count;
   logic [NUM_SLOTS-1:0] count_mask;
   logic                all_done;

   logic [NUM_SLOTS-1:0] done_ff;
   logic [NUM_SLOTS-1:0] fresh_ff;   // remaining still equals burst

   logic [19:0] now_tick_ff;
   logic [19:0] tick_now_ff;
   logic [19:0] idle_count_ff;
   logic [23:0] total_turn_ff;
   logic [23:0] total_wait_ff;

   logic [SLOT_W-1:0] scan_idx_ff;
   logic              eval_valid_ff;
   logic [SLOT_W-1:0] eval_slot_ff;
   logic              scan_last;

   pick_best_type  best;
   task_entry_type task_rd;
   task_entry_type task_wr;
   prog_entry_type prog_rd;
   prog_entry_type prog_wr;

   logic [SLOT_W-1:0] load_slot;
   logic              load_ok;
   logic              task_wr_en;
   logic              task_rd_en;
   logic              prog_rd_en;
   logic              prog_wr_en;
   logic              reply_try;

   // per-task results of the current word
   logic        res_busy_ff;
   logic        res_fin_ff;
   logic [19:0] res_finish_ff;
   logic [19:0] res_turn_ff;
   logic [19:0] res_wait_ff;
   logic [19:0] res_resp_ff;

   logic [15:0] rem_cur;
   logic [19:0] start_cur;
   logic        finishing;
   logic [19:0] turn_cur;
   logic [19:0] resp_cur;
   logic [19:0] wait_cur;
   logic [24:0] turn_sum;
   logic [24:0] wait_sum;
   logic [23:0] tw_next;

   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   logic         out_free;
   logic         req_accept;
   logic         csr_write;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {27'd0, task_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= 5'd1;
      end else if (csr_write && !csr_paddr[2]) begin
         task_count_ff <= csr_pwdata[4:0];
      end
   end

   always_comb begin
      if (32'(task_count_ff) > 32'(NUM_SLOTS)) begin
         eff_count = CNT_W'(NUM_SLOTS);
      end else begin
         eff_count = CNT_W'(task_count_ff);
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         count_mask[i] = (CNT_W'(i) < eff_count);
      end
      all_done = &(done_ff | ~count_mask);
   end

   // ---------------------------------------------------------------- request
   assign req_word   = req_word_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_tuser;
         item_ff <= req_word;
      end
   end

   assign load_slot = SLOT_W'(item_ff.slot);
   assign load_ok   = (kind_ff == KIND_LOAD) && (32'(item_ff.slot) < 32'(NUM_SLOTS));

   // ---------------------------------------------------------------- fsm
   assign scan_last = ({1'b0, scan_idx_ff} + CNT_W'(1)) == eff_count;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_tuser == KIND_TICK) && !all_done) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY:    state_in = ST_REPLY;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_FETCH;
         ST_FETCH:    state_in = best.found ? ST_UPDATE : ST_REPLY;
         ST_UPDATE:   state_in = ST_SETTLE;
         ST_SETTLE:   state_in = ST_REPLY;
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      task_wr_en = 1'b0;
      task_rd_en = 1'b0;
      prog_rd_en = 1'b0;
      prog_wr_en = 1'b0;
      reply_try  = 1'b0;
      unique case (state_ff)
         ST_APPLY:  task_wr_en = load_ok;
         ST_SCAN:   task_rd_en = 1'b1;
         ST_FETCH:  prog_rd_en = 1'b1;
         ST_UPDATE: prog_wr_en = 1'b1;
         ST_REPLY:  reply_try  = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- scan
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
      end else begin
         eval_valid_ff <= task_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      eval_slot_ff <= scan_idx_ff;
      if (req_accept) begin
         scan_idx_ff <= '0;
      end else if (task_rd_en) begin
         scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      task_wr.task_id        = item_ff.task_id;
      task_wr.priority_level = item_ff.priority_level;
      task_wr.burst_time     = (item_ff.burst_time == 16'd0) ? 16'd1 : item_ff.burst_time;
      task_wr.arrival_time   = item_ff.arrival_time;
   end

   psched_ram #(
      .WIDTH ($bits(task_entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (task_wr_en),
      .wr_addr (load_slot),
      .wr_data (task_wr),
      .rd_en   (task_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (task_rd)
   );

   psched_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_accept),
      .eval_valid (eval_valid_ff),
      .eval_slot  (eval_slot_ff),
      .eval_entry (task_rd),
      .eval_done  (done_ff[eval_slot_ff]),
      .now_tick   (now_tick_ff),
      .best       (best)
   );

   // ---------------------------------------------------------------- serve
   // a fresh slot has not been served since load or restart
   always_comb begin
      rem_cur   = fresh_ff[best.slot] ? best.burst_time : prog_rd.remaining;
      start_cur = fresh_ff[best.slot] ? tick_now_ff : prog_rd.start_time;
      finishing = (rem_cur <= 16'd1);
      prog_wr.remaining  = finishing ? 16'd0 : (rem_cur - 16'd1);
      prog_wr.start_time = start_cur;
      // now_tick already holds the finish tick here
      turn_cur = (now_tick_ff >= {4'd0, best.arrival_time})
         ? (now_tick_ff - {4'd0, best.arrival_time}) : 20'd0;
      resp_cur = (start_cur >= {4'd0, best.arrival_time})
         ? (start_cur - {4'd0, best.arrival_time}) : 20'd0;
      wait_cur = (res_turn_ff >= {4'd0, best.burst_time})
         ? (res_turn_ff - {4'd0, best.burst_time}) : 20'd0;
      turn_sum = {1'b0, total_turn_ff} + {5'd0, res_turn_ff};
      wait_sum = {1'b0, total_wait_ff} + {5'd0, res_wait_ff};
      if (!res_fin_ff) begin
         tw_next = total_wait_ff;
      end else if (wait_sum > {1'b0, MAX24}) begin
         tw_next = MAX24;
      end else begin
         tw_next = wait_sum[23:0];
      end
   end

   psched_ram #(
      .WIDTH ($bits(prog_entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_wr_en),
      .wr_addr (best.slot),
      .wr_data (prog_wr),
      .rd_en   (prog_rd_en),
      .rd_addr (best.slot),
      .rd_data (prog_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         fresh_ff <= '0;
      end else begin
         if (state_ff == ST_APPLY) begin
            if (load_ok) begin
               done_ff[load_slot]  <= 1'b0;
               fresh_ff[load_slot] <= 1'b1;
            end else if (kind_ff == KIND_RESTART) begin
               done_ff  <= '0;
               fresh_ff <= '1;
            end
         end else if (state_ff == ST_UPDATE) begin
            fresh_ff[best.slot] <= 1'b0;
            if (finishing) begin
               done_ff[best.slot] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_tick_ff   <= '0;
         idle_count_ff <= '0;
         total_turn_ff <= '0;
         total_wait_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_APPLY: begin
               if (kind_ff == KIND_RESTART) begin
                  now_tick_ff   <= '0;
                  idle_count_ff <= '0;
                  total_turn_ff <= '0;
                  total_wait_ff <= '0;
               end
            end
            ST_FETCH: begin
               if (now_tick_ff != MAX20) begin
                  now_tick_ff <= now_tick_ff + 20'd1;
               end
               if (!best.found && (idle_count_ff != MAX20)) begin
                  idle_count_ff <= idle_count_ff + 20'd1;
               end
            end
            ST_SETTLE: begin
               if (res_fin_ff) begin
                  total_turn_ff <= (turn_sum > {1'b0, MAX24}) ? MAX24 : turn_sum[23:0];
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  total_wait_ff <= tw_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_busy_ff <= 1'b0;
         res_fin_ff  <= 1'b0;
      end else if (req_accept) begin
         res_busy_ff <= 1'b0;
         res_fin_ff  <= 1'b0;
      end else if (state_ff == ST_UPDATE) begin
         res_busy_ff <= 1'b1;
         res_fin_ff  <= finishing;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         res_finish_ff <= '0;
         res_turn_ff   <= '0;
         res_wait_ff   <= '0;
         res_resp_ff   <= '0;
      end else if (state_ff == ST_FETCH) begin
         tick_now_ff <= now_tick_ff;
      end else if ((state_ff == ST_UPDATE) && finishing) begin
         res_finish_ff <= now_tick_ff;
         res_turn_ff   <= turn_cur;
         res_resp_ff   <= resp_cur;
      end else if ((state_ff == ST_SETTLE) && res_fin_ff) begin
         res_wait_ff <= wait_cur;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_in                = '0;
      rsp_in.busy_res       = res_busy_ff;
      rsp_in.run_slot       = res_busy_ff ? 4'(best.slot) : 4'd0;
      rsp_in.run_id         = res_busy_ff ? best.task_id : 8'd0;
      rsp_in.finished       = res_fin_ff;
      rsp_in.finish_time    = res_finish_ff;
      rsp_in.turnaround     = res_turn_ff;
      rsp_in.waiting        = res_wait_ff;
      rsp_in.response       = res_resp_ff;
      rsp_in.all_done       = all_done;
      rsp_in.sum_turnaround = total_turn_ff;
      rsp_in.sum_waiting    = tw_next;
      rsp_in.idle_ticks     = idle_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (reply_try && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_try && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == ST_SCAN, CNT_W'(scan_idx_ff) < eff_count)
   `ASSERT_NEXT(a_done_set_on_update, clock, reset, state_ff != ST_UPDATE, $countones(done_ff) <= $past($countones(done_ff)))
   `ASSERT_NEXT(a_time_moves_on_tick, clock, reset, state_ff != ST_FETCH && state_ff != ST_APPLY, $stable(now_tick_ff))
   `ASSERT_ALWAYS(a_finish_is_busy, clock, reset, !res_fin_ff || res_busy_ff)

endmodule

// File: rtl/psched_ram.sv
// ----------------------------------------------------------------------------
// psched_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module psched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/psched_pick.sv
// ----------------------------------------------------------------------------
// psched_pick
// running best-candidate compare for the slot scan, one slot per cycle
// ----------------------------------------------------------------------------
module psched_pick import psched_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              eval_valid,
   input  logic [SLOT_W-1:0] eval_slot,
   input  task_entry_type    eval_entry,
   input  logic              eval_done,
   input  logic [19:0]       now_tick,
   output pick_best_type     best
);

   pick_best_type best_ff;
   pick_best_type best_in;
   logic          ready;
   logic          better;

   always_comb begin
      ready  = !eval_done && ({4'b0, eval_entry.arrival_time} <= now_tick);
      better = !best_ff.found
         || (eval_entry.priority_level < best_ff.priority_level)
         || ((eval_entry.priority_level == best_ff.priority_level)
             && (eval_entry.arrival_time < best_ff.arrival_time));
      best_in = best_ff;
      if (clear) begin
         best_in.found = 1'b0;
      end else if (eval_valid && ready && better) begin
         best_in.found          = 1'b1;
         best_in.slot           = eval_slot;
         best_in.arrival_time   = eval_entry.arrival_time;
         best_in.burst_time     = eval_entry.burst_time;
         best_in.priority_level = eval_entry.priority_level;
         best_in.task_id        = eval_entry.task_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule
